// File: rtl/stsr_pkg.sv
package stsr_pkg;

  localparam int unsigned MAX_TERMS_DEF = 1024;
  localparam int unsigned SUM_W         = 41;
  localparam int unsigned PROD_W        = 2 * SUM_W;
  localparam int unsigned DIVN_W        = PROD_W + 32;
  localparam int unsigned QUO_W         = 34;
  localparam int unsigned AREA_W        = 34;
  localparam int unsigned CNT_STEP_W    = 7;
  localparam int unsigned MUL_STEPS     = SUM_W;
  localparam int unsigned DIV_STEPS     = DIVN_W;
  localparam int unsigned SQRT_STEPS    = 16;
  localparam logic [16:0] Q16_ONE       = 17'h10000;
  localparam logic [16:0] MIX_RESET     = 17'h08000;
  localparam logic [2:0]  REG_MIX_ADDR  = 3'd0;

  typedef enum logic [8:0] {
    S_ACC  = 9'b000000001,
    S_LD   = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIVC = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_COS  = 9'b000100000,
    S_DIVA = 9'b001000000,
    S_RAT  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic acc;
    logic rect_ld;
    logic area_ld;
    logic mul_ld;
    logic mul_step;
    logic divc_ld;
    logic diva_ld;
    logic div_step;
    logic sq_ld;
    logic sq_step;
    logic cos_ld;
    logic rat_ld;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Extent of one axis: max - min, or zero when the bounds are inverted.
  function automatic logic [16:0] extent(input logic signed [15:0] lo,
                                         input logic signed [15:0] hi);
    logic signed [16:0] d;
    d = 17'(hi) - 17'(lo);
    return (hi >= lo) ? 17'(d) : 17'd0;
  endfunction

endpackage

// File: rtl/stsr_ctrl.sv
module stsr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_element,
  output logic            in_ready,
  input  stsr_pkg::stat_t stat,
  output stsr_pkg::cmd_t  cmd
);
  import stsr_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CNT_STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                    first;

  assign first    = (cnt_r == '0);
  assign in_ready = (state_r == S_ACC);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        cnt_nxt = '0;
        cmd.acc = in_valid;
        if (in_valid && in_last_element) begin
          cmd.rect_ld = 1'b1;
          state_nxt   = S_LD;
        end
      end
      S_LD: begin
        cmd.area_ld = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_ld   = first;
        cmd.mul_step = !first;
        if (cnt_r == CNT_STEP_W'(MUL_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVC;
        end
      end
      S_DIVC: begin
        cmd.divc_ld  = first;
        cmd.div_step = !first;
        if (cnt_r == CNT_STEP_W'(DIV_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sq_ld   = first;
        cmd.sq_step = !first;
        if (cnt_r == CNT_STEP_W'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_COS;
        end
      end
      S_COS: begin
        cmd.cos_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIVA;
      end
      S_DIVA: begin
        cmd.diva_ld  = first;
        cmd.div_step = !first;
        if (cnt_r == CNT_STEP_W'(DIV_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_RAT;
        end
      end
      S_RAT: begin
        cmd.rat_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cnt_nxt = '0;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/stsr_dpath.sv
module stsr_dpath #(
  parameter int unsigned MAX_TERMS = stsr_pkg::MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stsr_pkg::cmd_t      cmd,
  output stsr_pkg::stat_t     stat,
  input  logic [16:0]         mix,
  input  logic [15:0]         in_weight_a,
  input  logic [15:0]         in_weight_b,
  input  logic signed [15:0]  in_prior_min_x,
  input  logic signed [15:0]  in_prior_min_y,
  input  logic signed [15:0]  in_prior_max_x,
  input  logic signed [15:0]  in_prior_max_y,
  input  logic signed [15:0]  in_new_min_x,
  input  logic signed [15:0]  in_new_min_y,
  input  logic signed [15:0]  in_new_max_x,
  input  logic signed [15:0]  in_new_max_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [16:0]         out_score,
  output logic [16:0]         out_cosine,
  output logic [16:0]         out_area_ratio,
  output logic [1:0]          out_status
);
  import stsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  // Accumulators
  logic [SUM_W-1:0] dot_r, na_r, nb_r;
  logic [CNT_W-1:0] terms_r;
  logic [31:0]      p_ab, p_aa, p_bb;
  logic [SUM_W:0]   s_ab, s_aa, s_bb;
  logic             take;

  // Latched rectangles and areas
  logic signed [15:0] pminx_r, pminy_r, pmaxx_r, pmaxy_r;
  logic signed [15:0] nminx_r, nminy_r, nmaxx_r, nmaxy_r;
  logic [16:0]        ex_p, ey_p, ex_u, ey_u;
  logic signed [15:0] uminx, uminy, umaxx, umaxy;
  logic [AREA_W-1:0]  parea_r, uarea_r;

  // Shift-add multipliers for na*nb and dot*dot
  logic [PROD_W-1:0] mna_r, mdot_r, pn_r, pd_r;
  logic [SUM_W-1:0]  mnb_r, mdb_r;

  // Shared restoring divider
  logic [DIVN_W-1:0] dv_n_r;
  logic [PROD_W-1:0] dv_d_r;
  logic [PROD_W:0]   dv_rem_r, dv_r2;
  logic [QUO_W-1:0]  dv_q_r;
  logic              dv_ovf_r, dv_ge;

  // Integer square root
  logic [31:0] sq_v_r, sq_tt;
  logic [15:0] sq_r, sq_bit_r, sq_t;
  logic        cos_big_r;

  logic        zero_norm, zero_area;
  logic [16:0] cos_r, rat_r, alpha_n;
  logic [33:0] m1, m2;
  logic [34:0] msum;

  logic        out_valid_r;
  logic [16:0] score_r, ocos_r, orat_r;
  logic [1:0]  ostat_r;

  assign p_ab = in_weight_a * in_weight_b;
  assign p_aa = in_weight_a * in_weight_a;
  assign p_bb = in_weight_b * in_weight_b;
  assign s_ab = {1'b0, dot_r} + (SUM_W + 1)'(p_ab);
  assign s_aa = {1'b0, na_r}  + (SUM_W + 1)'(p_aa);
  assign s_bb = {1'b0, nb_r}  + (SUM_W + 1)'(p_bb);
  assign take = cmd.acc && (terms_r < CNT_W'(MAX_TERMS));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_ld) begin
      dot_r   <= '0;
      na_r    <= '0;
      nb_r    <= '0;
      terms_r <= '0;
    end else if (take) begin
      dot_r   <= s_ab[SUM_W] ? '1 : s_ab[SUM_W-1:0];
      na_r    <= s_aa[SUM_W] ? '1 : s_aa[SUM_W-1:0];
      nb_r    <= s_bb[SUM_W] ? '1 : s_bb[SUM_W-1:0];
      terms_r <= terms_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rect_ld) begin
      pminx_r <= in_prior_min_x;
      pminy_r <= in_prior_min_y;
      pmaxx_r <= in_prior_max_x;
      pmaxy_r <= in_prior_max_y;
      nminx_r <= in_new_min_x;
      nminy_r <= in_new_min_y;
      nmaxx_r <= in_new_max_x;
      nmaxy_r <= in_new_max_y;
    end
  end

  assign uminx = (nminx_r < pminx_r) ? nminx_r : pminx_r;
  assign uminy = (nminy_r < pminy_r) ? nminy_r : pminy_r;
  assign umaxx = (nmaxx_r > pmaxx_r) ? nmaxx_r : pmaxx_r;
  assign umaxy = (nmaxy_r > pmaxy_r) ? nmaxy_r : pmaxy_r;
  assign ex_p  = extent(pminx_r, pmaxx_r);
  assign ey_p  = extent(pminy_r, pmaxy_r);
  assign ex_u  = extent(uminx, umaxx);
  assign ey_u  = extent(uminy, umaxy);

  always_ff @(posedge clk) begin
    if (cmd.area_ld) begin
      parea_r <= ex_p * ey_p;
      uarea_r <= ex_u * ey_u;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      mna_r  <= PROD_W'(na_r);
      mnb_r  <= nb_r;
      pn_r   <= '0;
      mdot_r <= PROD_W'(dot_r);
      mdb_r  <= dot_r;
      pd_r   <= '0;
    end else if (cmd.mul_step) begin
      if (mnb_r[0]) pn_r <= pn_r + mna_r;
      if (mdb_r[0]) pd_r <= pd_r + mdot_r;
      mna_r  <= mna_r << 1;
      mnb_r  <= mnb_r >> 1;
      mdot_r <= mdot_r << 1;
      mdb_r  <= mdb_r >> 1;
    end
  end

  assign dv_r2 = {dv_rem_r[PROD_W-1:0], dv_n_r[DIVN_W-1]};
  assign dv_ge = (dv_r2 >= {1'b0, dv_d_r});

  always_ff @(posedge clk) begin
    if (cmd.divc_ld || cmd.diva_ld) begin
      dv_n_r   <= cmd.divc_ld ? {pd_r, 32'd0} : DIVN_W'({parea_r, 16'd0});
      dv_d_r   <= cmd.divc_ld ? pn_r : PROD_W'(uarea_r);
      dv_rem_r <= '0;
      dv_q_r   <= '0;
      dv_ovf_r <= 1'b0;
    end else if (cmd.div_step) begin
      dv_rem_r <= dv_ge ? dv_r2 - {1'b0, dv_d_r} : dv_r2;
      dv_n_r   <= dv_n_r << 1;
      dv_q_r   <= {dv_q_r[QUO_W-2:0], dv_ge};
      dv_ovf_r <= dv_ovf_r | dv_q_r[QUO_W-1];
    end
  end

  assign sq_t  = sq_r | sq_bit_r;
  assign sq_tt = sq_t * sq_t;

  always_ff @(posedge clk) begin
    if (cmd.sq_ld) begin
      sq_v_r    <= dv_q_r[31:0];
      cos_big_r <= dv_ovf_r | (dv_q_r[QUO_W-1:32] != '0);
      sq_r      <= '0;
      sq_bit_r  <= 16'h8000;
    end else if (cmd.sq_step) begin
      if (sq_tt <= sq_v_r) sq_r <= sq_t;
      sq_bit_r <= sq_bit_r >> 1;
    end
  end

  assign zero_norm = (na_r == '0) || (nb_r == '0);
  assign zero_area = (parea_r == '0) || (uarea_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.cos_ld) begin
      cos_r <= zero_norm ? 17'd0 : (cos_big_r ? Q16_ONE : {1'b0, sq_r});
    end
    if (cmd.rat_ld) begin
      if (zero_area) begin
        rat_r <= 17'd0;
      end else if (dv_ovf_r || (dv_q_r > QUO_W'(Q16_ONE))) begin
        rat_r <= Q16_ONE;
      end else begin
        rat_r <= dv_q_r[16:0];
      end
    end
  end

  assign alpha_n = Q16_ONE - mix;
  assign m1      = mix * rat_r;
  assign m2      = alpha_n * cos_r;
  assign msum    = {1'b0, m1} + {1'b0, m2};

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      score_r <= msum[32:16];
      ocos_r  <= cos_r;
      orat_r  <= rat_r;
      ostat_r <= {zero_area, zero_norm};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_score      = score_r;
  assign out_cosine     = ocos_r;
  assign out_area_ratio = orat_r;
  assign out_status     = ostat_r;

endmodule

// File: rtl/spatial_text_relevance_score.sv
// After the edge that takes a beat with in_last_element set, the controller runs an area
// load, the multiply, a divide for the cosine, the root, a cosine load, a divide for the
// area ratio, a ratio load and an output load, with which out_valid rises.
// Throughput: one weight beat per cycle while accumulating; in_ready returns with the
// output load, which waits while an unaccepted result blocks the output register.
// Reset (synchronous, rst_n low) clears the sums, the state machine and out_valid;
// the mix is 32768.
module spatial_text_relevance_score #(
  parameter int unsigned MAX_TERMS = stsr_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_weight_a,
  input  logic [15:0]        in_weight_b,
  input  logic               in_last_element,
  input  logic signed [15:0] in_prior_min_x,
  input  logic signed [15:0] in_prior_min_y,
  input  logic signed [15:0] in_prior_max_x,
  input  logic signed [15:0] in_prior_max_y,
  input  logic signed [15:0] in_new_min_x,
  input  logic signed [15:0] in_new_min_y,
  input  logic signed [15:0] in_new_max_x,
  input  logic signed [15:0] in_new_max_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        out_score,
  output logic [16:0]        out_cosine,
  output logic [16:0]        out_area_ratio,
  output logic [1:0]         out_status
);
  import stsr_pkg::*;

  // The mix register holds alpha in Q1.16 from pwdata[16:0]. Values above one are
  // clamped to one so the text weight never goes negative.
  logic [16:0] mix_r, mix_nxt, wr_val;
  logic        wr_en;
  cmd_t        cmd;
  stat_t       stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (paddr == REG_MIX_ADDR);
  assign wr_val  = pwdata[16:0];
  assign mix_nxt = (wr_val > Q16_ONE) ? Q16_ONE : wr_val;
  assign prdata  = (paddr == REG_MIX_ADDR) ? {15'd0, mix_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= MIX_RESET;
    end else if (wr_en) begin
      mix_r <= mix_nxt;
    end
  end

  // The controller sequences the end-of-vector math; weight beats are taken
  // only while it sits in the accumulate state.
  stsr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_ready        (in_ready),
    .stat            (stat),
    .cmd             (cmd)
  );

  // The datapath holds the saturating sums, the shift-add multipliers, the
  // shared divider, the square root unit and the output register.
  stsr_dpath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .mix            (mix_r),
    .in_weight_a    (in_weight_a),
    .in_weight_b    (in_weight_b),
    .in_prior_min_x (in_prior_min_x),
    .in_prior_min_y (in_prior_min_y),
    .in_prior_max_x (in_prior_max_x),
    .in_prior_max_y (in_prior_max_y),
    .in_new_min_x   (in_new_min_x),
    .in_new_min_y   (in_new_min_y),
    .in_new_max_x   (in_new_max_x),
    .in_new_max_y   (in_new_max_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_score      (out_score),
    .out_cosine     (out_cosine),
    .out_area_ratio (out_area_ratio),
    .out_status     (out_status)
  );

endmodule

// File: rtl/stsr_checker.sv
module stsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_element,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_score,
  input logic [16:0] out_cosine,
  input logic [16:0] out_area_ratio,
  input logic [1:0]  out_status
);

  // A stalled result beat holds its score.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result beat changed while stalled");

  // The block stops taking beats right after a vector's last beat.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_element |=> !in_ready)
    else $error("input taken during end-of-vector math");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status[0] |-> out_cosine == 17'd0)
    else $error("cosine nonzero with zero norm");

  a_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status[1] |-> out_area_ratio == 17'd0)
    else $error("ratio nonzero with zero prior area");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= 17'h10000)
    else $error("score above one");

endmodule

bind spatial_text_relevance_score stsr_checker u_stsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_element (in_last_element),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_score       (out_score),
  .out_cosine      (out_cosine),
  .out_area_ratio  (out_area_ratio),
  .out_status      (out_status)
);

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsr_pkg::*;

  // One input beat: a weight pair, the end-of-vector flag and the two rectangles.
  // The rectangle order is prior min x, min y, max x, max y, then the same for
  // the added rectangle.
  typedef struct {
    logic [15:0]        wa;
    logic [15:0]        wb;
    logic               last;
    logic signed [15:0] r[8];
  } pair_beat_t;

  typedef struct {
    logic [16:0] score;
    logic [16:0] cosine;
    logic [16:0] ratio;
    logic [1:0]  status;
  } relevance_t;

  // Scoreboard: it keeps its own copy of the accumulators and the mix, and it
  // queues the relevance result that every end-of-vector beat should produce.
  class relevance_board;
    longint unsigned mix = 32768;
    longint unsigned dot_acc, na_acc, nb_acc;
    int              term_cnt;
    relevance_t      expected_scores[$];
    int              errors;
    int              results_seen;

    localparam longint unsigned SUM_MAX = (64'd1 << 41) - 1;

    function void set_mix(longint unsigned v);
      v = v & 64'h1FFFF;
      mix = (v > 65536) ? 65536 : v;
    endfunction

    function longint unsigned sat_sum(longint unsigned s, longint unsigned p);
      s = s + p;
      return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    function longint unsigned span(longint lo, longint hi);
      return (hi >= lo) ? longint'(hi - lo) : 0;
    endfunction

    // Largest c in [0, 1.0] with c^2 * na * nb <= dot^2, found by bisection in Q1.16.
    function longint unsigned cosine_q16(longint unsigned d, longint unsigned na,
                                         longint unsigned nb);
      logic [129:0]    nn, tgt, lhs;
      longint unsigned lo, hi, mid;
      nn  = 130'(na) * 130'(nb);
      tgt = (130'(d) * 130'(d)) << 32;
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = nn * 130'(mid * mid);
        if (lhs <= tgt) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function void absorb_beat(pair_beat_t b);
      longint unsigned wa, wb, cosv, ratio, parea, uarea, score;
      longint          p[8];
      logic [1:0]      st;
      relevance_t      r;
      wa = b.wa;
      wb = b.wb;
      // Pairs beyond the term limit do not touch the sums.
      if (term_cnt < MAX_TERMS_DEF) begin
        dot_acc = sat_sum(dot_acc, wa * wb);
        na_acc  = sat_sum(na_acc, wa * wa);
        nb_acc  = sat_sum(nb_acc, wb * wb);
        term_cnt++;
      end
      if (!b.last) return;
      st = 2'b00;
      cosv = 0;
      ratio = 0;
      if (na_acc == 0 || nb_acc == 0) st[0] = 1'b1;
      else cosv = cosine_q16(dot_acc, na_acc, nb_acc);
      foreach (p[i]) p[i] = b.r[i];
      parea = span(p[0], p[2]) * span(p[1], p[3]);
      // The union takes the outer bounds even when the added box is inverted.
      uarea = span((p[0] < p[4]) ? p[0] : p[4], (p[2] > p[6]) ? p[2] : p[6]) *
              span((p[1] < p[5]) ? p[1] : p[5], (p[3] > p[7]) ? p[3] : p[7]);
      if (parea == 0 || uarea == 0) st[1] = 1'b1;
      else begin
        ratio = (parea << 16) / uarea;
        if (ratio > 65536) ratio = 65536;
      end
      score = (mix * ratio + (65536 - mix) * cosv) >> 16;
      r.score  = 17'(score);
      r.cosine = 17'(cosv);
      r.ratio  = 17'(ratio);
      r.status = st;
      expected_scores.insert(expected_scores.size(), r);
      dot_acc  = 0;
      na_acc   = 0;
      nb_acc   = 0;
      term_cnt = 0;
    endfunction

    function void compare_result(relevance_t got);
      relevance_t want;
      results_seen++;
      if (expected_scores.size() == 0) begin
        $error("result beat with nothing expected: score %0d", got.score);
        errors++;
        return;
      end
      want = expected_scores.pop_front();
      if (got.score !== want.score) begin
        $error("score: expected %0d, got %0d", want.score, got.score);
        errors++;
      end
      if (got.cosine !== want.cosine) begin
        $error("cosine: expected %0d, got %0d", want.cosine, got.cosine);
        errors++;
      end
      if (got.ratio !== want.ratio) begin
        $error("area_ratio: expected %0d, got %0d", want.ratio, got.ratio);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_weight_a = '0;
  logic [15:0]        in_weight_b = '0;
  logic               in_last_element = 1'b0;
  logic signed [15:0] in_prior_min_x = '0;
  logic signed [15:0] in_prior_min_y = '0;
  logic signed [15:0] in_prior_max_x = '0;
  logic signed [15:0] in_prior_max_y = '0;
  logic signed [15:0] in_new_min_x = '0;
  logic signed [15:0] in_new_min_y = '0;
  logic signed [15:0] in_new_max_x = '0;
  logic signed [15:0] in_new_max_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        out_score;
  logic [16:0]        out_cosine;
  logic [16:0]        out_area_ratio;
  logic [1:0]         out_status;

  spatial_text_relevance_score dut (.*);

  always #10 clk = ~clk;

  relevance_board board = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 70;
  int beats_sent = 0;
  int stall_cycles = 0;
  localparam int STALL_LIMIT = 20000;

  // The receiver decides its ready for the coming edge at each falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are sampled at the rising edge, where the handshake takes place.
  // The same process runs the watchdog: any cycle that moves a beat on either
  // channel resets it.
  always @(posedge clk) begin
    relevance_t got;
    if (rst_n && out_valid && out_ready) begin
      got.score  = out_score;
      got.cosine = out_cosine;
      got.ratio  = out_area_ratio;
      got.status = out_status;
      board.compare_result(got);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // APB write: a setup cycle, then an access cycle; pready is always high, so
  // the register takes the value at the edge that ends the access cycle.
  task automatic write_mix(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_MIX_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_mix(v);
  endtask

  // Sends one beat, with a random gap in front of it while the sender idles.
  // Valid stays high across back-to-back beats; only the payload changes.
  task automatic push_beat(input pair_beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_weight_a     <= b.wa;
    in_weight_b     <= b.wb;
    in_last_element <= b.last;
    in_prior_min_x  <= b.r[0];
    in_prior_min_y  <= b.r[1];
    in_prior_max_x  <= b.r[2];
    in_prior_max_y  <= b.r[3];
    in_new_min_x    <= b.r[4];
    in_new_min_y    <= b.r[5];
    in_new_max_x    <= b.r[6];
    in_new_max_y    <= b.r[7];
    do @(posedge clk); while (!in_ready);
    board.absorb_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  // Holds the input off until every queued result has come back, then gives
  // the block a few more cycles to settle into accumulation.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.expected_scores.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic pair_beat_t make_beat(logic [15:0] wa, logic [15:0] wb, logic last,
                                           int pmnx, int pmny, int pmxx, int pmxy,
                                           int nmnx, int nmny, int nmxx, int nmxy);
    pair_beat_t b;
    b.wa = wa;
    b.wb = wb;
    b.last = last;
    b.r[0] = 16'(pmnx); b.r[1] = 16'(pmny); b.r[2] = 16'(pmxx); b.r[3] = 16'(pmxy);
    b.r[4] = 16'(nmnx); b.r[5] = 16'(nmny); b.r[6] = 16'(nmxx); b.r[7] = 16'(nmxy);
    return b;
  endfunction

  // Random rectangles: often proper boxes, sometimes a flat or inverted prior
  // box, an inverted added box, a box inside the prior one, or raw noise.
  function automatic void random_rects(ref pair_beat_t b);
    int m;
    m = $urandom_range(9);
    foreach (b.r[i]) b.r[i] = 16'($urandom);
    case (m)
      0, 1, 2, 3: begin
        b.r[0] = 16'($urandom_range(0, 40000) - 32768);
        b.r[1] = 16'($urandom_range(0, 40000) - 32768);
        b.r[2] = 16'(int'(b.r[0]) + $urandom_range(1, 25000));
        b.r[3] = 16'(int'(b.r[1]) + $urandom_range(1, 25000));
        b.r[4] = 16'(int'(b.r[0]) + $urandom_range(0, 4000) - 2000);
        b.r[5] = 16'(int'(b.r[1]) + $urandom_range(0, 4000) - 2000);
        b.r[6] = 16'(int'(b.r[4]) + $urandom_range(0, 8000));
        b.r[7] = 16'(int'(b.r[5]) + $urandom_range(0, 8000));
        if (b.r[2] < b.r[0]) b.r[2] = 16'sh7fff;
        if (b.r[3] < b.r[1]) b.r[3] = 16'sh7fff;
      end
      4: begin
        b.r[0] = 16'($urandom_range(0, 20000) - 10000);
        b.r[1] = 16'($urandom_range(0, 20000) - 10000);
        b.r[2] = b.r[0] + 16'sd5000;
        b.r[3] = b.r[1] + 16'sd5000;
        b.r[4] = b.r[0] + 16'sd10;
        b.r[5] = b.r[1] + 16'sd10;
        b.r[6] = b.r[2] - 16'sd10;
        b.r[7] = b.r[3] - 16'sd10;
      end
      5: b.r[2] = b.r[0];
      default: ;
    endcase
  endfunction

  // A random vector: its length and the style of its weights are drawn once,
  // and only its final beat carries meaningful rectangles.
  task automatic random_vector();
    int         len, style;
    pair_beat_t b;
    len   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    style = $urandom_range(5);
    for (int k = 0; k < len; k++) begin
      foreach (b.r[i]) b.r[i] = 16'($urandom);
      case (style)
        0: begin b.wa = 16'($urandom); b.wb = 16'($urandom); end
        1: begin
          b.wa = 16'($urandom_range(0, 32768));
          b.wb = 16'($urandom_range(0, 32768));
        end
        2: begin b.wa = 16'($urandom_range(0, 32768)); b.wb = b.wa; end
        3: begin b.wa = 16'($urandom_range(0, 32768)); b.wb = '0; end
        4: begin b.wa = 16'($urandom_range(0, 15)); b.wb = 16'($urandom_range(0, 15)); end
        default: begin
          b.wa = ($urandom_range(1)) ? 16'($urandom) : '0;
          b.wb = ($urandom_range(1)) ? 16'($urandom) : '0;
        end
      endcase
      b.last = (k == len - 1);
      if (b.last) random_rects(b);
      push_beat(b);
    end
  endtask

  task automatic random_phase(input int beat_goal);
    int goal;
    goal = beats_sent + beat_goal;
    while (beats_sent < goal) begin
      random_vector();
      // Now and then the sender waits for the result pipe to empty.
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  initial begin
    pair_beat_t b;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, under the reset mix of one half.
    // Full weights on both sides and a box equal to its union.
    push_beat(make_beat(16'h8000, 16'h8000, 1, -100, -100, 100, 100, -100, -100, 100, 100));
    // Top of the weight field, beyond Q1.15 one.
    push_beat(make_beat(16'hffff, 16'h0001, 1, -32768, -32768, 32767, 32767,
                        0, 0, 1, 1));
    // Orthogonal vectors give a zero cosine with nonzero norms.
    push_beat(make_beat(16'h4000, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_beat(make_beat(16'h0000, 16'h4000, 1, 0, 0, 10, 10, 20, 20, 30, 30));
    // A zero norm on one side.
    push_beat(make_beat(16'h0000, 16'h7fff, 1, 0, 0, 5, 7, -5, -7, 0, 0));
    // Zero prior area from a flat box, with a zero norm too: both status bits.
    push_beat(make_beat(16'h0000, 16'h0000, 1, 3, 0, 3, 100, 0, 0, 50, 50));
    // Inverted prior box.
    push_beat(make_beat(16'h1234, 16'h4321, 1, 10, 10, -10, -10, 0, 0, 1, 1));
    // Inverted added box: the union still spans the outer bounds.
    push_beat(make_beat(16'h2000, 16'h3000, 1, 0, 0, 100, 100, 300, 300, -200, -200));
    // Extreme bounds on every rectangle field.
    push_beat(make_beat(16'h8000, 16'h7fff, 1, 32767, 32767, -32768, -32768,
                        -32768, -32768, 32767, 32767));
    push_beat(make_beat(16'h0001, 16'h0001, 1, -32768, 0, 0, 1,
                        32767, 32767, 32767, 32767));
    // A short vector with mixed weights.
    push_beat(make_beat(16'h8000, 16'h0100, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_beat(make_beat(16'h0100, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_beat(make_beat(16'h5555, 16'haaaa, 1, -50, -60, 70, 80, -90, 0, 10, 200));
    drain_results();

    // Phase one: fast sender, slow receiver, no spatial weight.
    write_mix(32'd0);
    send_idle_pct = 28;
    recv_idle_pct = 70;
    random_phase(250);
    drain_results();

    // Phase two: the other way round; an oversized write must clamp to one.
    write_mix(32'h0001ffff);
    send_idle_pct = 70;
    recv_idle_pct = 28;
    random_phase(150);
    drain_results();
    write_mix(32'd65536);
    random_phase(100);
    drain_results();

    // Phase three: no idling. One vector runs past the term limit with full
    // weights, so the sums saturate and the extra pairs are dropped.
    write_mix(32'($urandom_range(1, 65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < MAX_TERMS_DEF + 6; k++) begin
      b = make_beat(16'hffff, (k % 3 == 0) ? 16'hffff : 16'h8000, 0,
                    0, 0, 0, 0, 0, 0, 0, 0);
      b.last = (k == MAX_TERMS_DEF + 5);
      if (b.last) random_rects(b);
      push_beat(b);
    end
    random_phase(250);
    drain_results();

    in_valid <= 1'b0;
    repeat (400) @(negedge clk);
    if (board.expected_scores.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_scores.size());
      board.errors++;
    end
    $display("Run covered %0d input beats and %0d relevance results over four mix settings,",
             beats_sent, board.results_seen);
    $display("including zero norms, degenerate boxes, inverted boxes and the term limit.");
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/stsr_pkg.sv
rtl/stsr_ctrl.sv
rtl/stsr_dpath.sv
rtl/spatial_text_relevance_score.sv
rtl/stsr_checker.sv
test/tb.sv
